// ===== rtl/core/min_max_normalize_assert.svh =====
// Assertion helpers used by the min-max normalize controller.
`ifndef MIN_MAX_NORMALIZE_ASSERT_SVH
`define MIN_MAX_NORMALIZE_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define MMN_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define MMN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/mmn_pkg.sv =====
// ----------------------------------------------------------------------------
// mmn_pkg
// Shared constants, types and controller/datapath signal groups for the
// min-max normalize block.
// ----------------------------------------------------------------------------
package mmn_pkg;

    localparam int DEPTH     = 4096;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int PIX_W     = 32;
    localparam int QUO_W     = 17;
    localparam int DIV_STEPS = QUO_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_DIVIDE,
        ST_HOLD
    } mmn_state_t;

    typedef struct packed {
        logic load_en;
        logic read_start;
        logic capture;
        logic div_step;
        logic div_first;
        logic out_load;
    } mmn_cmd_t;

    typedef struct packed {
        logic frame_ready;
    } mmn_status_t;

endpackage

// ===== rtl/core/mmn_in_if.sv =====
// ----------------------------------------------------------------------------
// mmn_in_if
// Input channel: one load or read request per transaction.
// ----------------------------------------------------------------------------
interface mmn_in_if;

    logic        valid;
    logic        ready;
    logic        op;
    logic [31:0] pixel;
    logic        last;

    modport source (output valid, output op, output pixel, output last, input ready);
    modport sink   (input valid, input op, input pixel, input last, output ready);

endinterface

// ===== rtl/core/mmn_out_if.sv =====
// ----------------------------------------------------------------------------
// mmn_out_if
// Output channel: one normalized pixel per transaction.
// ----------------------------------------------------------------------------
interface mmn_out_if;

    logic        valid;
    logic        ready;
    logic [31:0] value;
    logic        last_res;

    modport source (output valid, output value, output last_res, input ready);
    modport sink   (input valid, input value, input last_res, output ready);

endinterface

// ===== rtl/core/mmn_ram.sv =====
// ----------------------------------------------------------------------------
// mmn_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module mmn_ram #(
    parameter int DATA_W    = 32,
    parameter int NUM_WORDS = 4096
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [$clog2(NUM_WORDS)-1:0] wr_addr,
    input  logic [DATA_W-1:0]            wr_data,
    input  logic                         rd_en,
    input  logic [$clog2(NUM_WORDS)-1:0] rd_addr,
    output logic [DATA_W-1:0]            rd_data
);

    logic [DATA_W-1:0] mem [NUM_WORDS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/core/mmn_ctrl.sv =====
// ----------------------------------------------------------------------------
// mmn_ctrl
// Controller: accepts transactions, sequences the store fetch and the
// bit-serial division, and owns the output valid flag.
// ----------------------------------------------------------------------------
`include "min_max_normalize_assert.svh"

module mmn_ctrl
    import mmn_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_op,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  mmn_status_t status,
    output mmn_cmd_t    cmd
);

    mmn_state_t        state_reg, state_next;
    logic [STEP_W-1:0] step_cnt_reg, step_cnt_next;
    logic              out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_cnt_reg  <= step_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        step_cnt_next = step_cnt_reg;
        cmd           = '0;
        in_ready      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_op == OP_LOAD)
                    begin
                        cmd.load_en = 1'b1;
                    end
                    else if (status.frame_ready)
                    begin
                        // A read with no closed frame is swallowed without a result.
                        cmd.read_start = 1'b1;
                        state_next     = ST_FETCH;
                    end
                end
            end
            ST_FETCH:
            begin
                cmd.capture   = 1'b1;
                step_cnt_next = STEP_W'(DIV_STEPS - 1);
                state_next    = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                cmd.div_step  = 1'b1;
                cmd.div_first = (step_cnt_reg == STEP_W'(DIV_STEPS - 1));
                if (step_cnt_reg == '0)
                begin
                    state_next = ST_HOLD;
                end
                else
                begin
                    step_cnt_next = step_cnt_reg - 1'b1;
                end
            end
            ST_HOLD:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

    `MMN_ASSERT_NOW(a_no_overwrite, cmd.out_load, !out_valid_reg || out_ready,
        "output register overwritten while a result is pending")
    `MMN_ASSERT_NEXT(a_read_to_fetch, cmd.read_start, state_reg == ST_FETCH,
        "accepted read did not move to the fetch state")
    `MMN_ASSERT_NEXT(a_div_to_hold, state_reg == ST_DIVIDE && step_cnt_reg == '0,
        state_reg == ST_HOLD, "division did not finish after the last step")
    `MMN_ASSERT_NOW(a_step_range, 1'b1, step_cnt_reg < STEP_W'(DIV_STEPS),
        "division step counter out of range")

endmodule

// ===== rtl/core/mmn_dpath.sv =====
// ----------------------------------------------------------------------------
// mmn_dpath
// Datapath: frame store, frame bookkeeping, running min and max, and a
// restoring divider that retires one quotient bit per step.
// ----------------------------------------------------------------------------
module mmn_dpath
    import mmn_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  mmn_cmd_t          cmd,
    output mmn_status_t       status,
    input  logic [PIX_W-1:0]  pixel,
    input  logic              last,
    output logic [PIX_W-1:0]  value,
    output logic              last_res
);

    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        rp_reg, rp_next;
    logic signed [PIX_W-1:0] min_reg, min_next;
    logic signed [PIX_W-1:0] max_reg, max_next;
    logic                    closed_reg, closed_next;

    logic                    last_flag_reg;
    logic                    flat_reg;
    logic [PIX_W-1:0]        raw_reg;
    logic [PIX_W:0]          rem_reg;
    logic [PIX_W-1:0]        den_reg;
    logic [QUO_W-1:0]        quo_reg;
    logic [PIX_W-1:0]        value_reg;
    logic                    last_res_reg;

    logic [CNT_W-1:0]        load_idx;
    logic                    store_en;
    logic signed [PIX_W-1:0] pixel_s;
    logic [CNT_W-1:0]        rp_eff;
    logic [CNT_W-1:0]        rp_plus;
    logic                    rd_last;
    logic [PIX_W-1:0]        rd_data;
    logic signed [PIX_W-1:0] rd_pixel;
    logic [PIX_W:0]          num_diff;
    logic [PIX_W:0]          den_diff;
    logic [PIX_W:0]          trial;
    logic [PIX_W:0]          trial_sub;

    assign pixel_s  = $signed(pixel);
    // A load after a closed frame starts a new one at index zero.
    assign load_idx = closed_reg ? '0 : count_reg;
    assign store_en = cmd.load_en && (load_idx < CNT_W'(DEPTH));

    assign rp_eff  = (rp_reg >= count_reg) ? '0 : rp_reg;
    assign rp_plus = rp_eff + 1'b1;
    assign rd_last = (rp_plus == count_reg);

    mmn_ram #(
        .DATA_W    (PIX_W),
        .NUM_WORDS (DEPTH)
    ) u_frame_store (
        .clk     (clk),
        .wr_en   (store_en),
        .wr_addr (load_idx[ADDR_W-1:0]),
        .wr_data (pixel),
        .rd_en   (cmd.read_start),
        .rd_addr (rp_eff[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    always_comb
    begin
        count_next  = count_reg;
        rp_next     = rp_reg;
        min_next    = min_reg;
        max_next    = max_reg;
        closed_next = closed_reg;

        if (cmd.load_en)
        begin
            if (closed_reg)
            begin
                count_next  = '0;
                rp_next     = '0;
                min_next    = '0;
                max_next    = '0;
                closed_next = 1'b0;
            end
            if (store_en)
            begin
                count_next = load_idx + 1'b1;
                if (load_idx == '0)
                begin
                    min_next = pixel_s;
                    max_next = pixel_s;
                end
                else
                begin
                    if (pixel_s < min_reg)
                    begin
                        min_next = pixel_s;
                    end
                    if (pixel_s > max_reg)
                    begin
                        max_next = pixel_s;
                    end
                end
            end
            if (last)
            begin
                closed_next = 1'b1;
                rp_next     = '0;
            end
        end
        else if (cmd.read_start)
        begin
            rp_next = rd_last ? '0 : rp_plus;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            rp_reg     <= '0;
            min_reg    <= '0;
            max_reg    <= '0;
            closed_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            rp_reg     <= rp_next;
            min_reg    <= min_next;
            max_reg    <= max_next;
            closed_reg <= closed_next;
        end
    end

    assign status.frame_ready = closed_reg && (count_reg != '0);

    // Both differences are non-negative and fit 32 unsigned bits.
    assign rd_pixel = $signed(rd_data);
    assign num_diff = {rd_pixel[PIX_W-1], rd_pixel} - {min_reg[PIX_W-1], min_reg};
    assign den_diff = {max_reg[PIX_W-1], max_reg} - {min_reg[PIX_W-1], min_reg};

    // The first step decides the integer bit, so the remainder is not shifted.
    assign trial     = cmd.div_first ? rem_reg : {rem_reg[PIX_W-1:0], 1'b0};
    assign trial_sub = trial - {1'b0, den_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.read_start)
        begin
            last_flag_reg <= rd_last;
        end
        if (cmd.capture)
        begin
            raw_reg  <= rd_data;
            flat_reg <= !(max_reg > min_reg);
            rem_reg  <= {1'b0, num_diff[PIX_W-1:0]};
            den_reg  <= den_diff[PIX_W-1:0];
            quo_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_reg <= trial_sub;
                quo_reg <= {quo_reg[QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[QUO_W-2:0], 1'b0};
            end
        end
        if (cmd.out_load)
        begin
            value_reg    <= flat_reg ? raw_reg : {{(PIX_W - QUO_W){1'b0}}, quo_reg};
            last_res_reg <= last_flag_reg;
        end
    end

    assign value    = value_reg;
    assign last_res = last_res_reg;

endmodule

// ===== rtl/core/min_max_normalize.sv =====
// ----------------------------------------------------------------------------
// min_max_normalize
// Min-max normalization (contrast stretch) of one grayscale Q16.16 frame.
// ----------------------------------------------------------------------------
// While the frame store has room, a load transaction writes the pixel to this
// 4096-entry store and updates the running minimum and maximum. A read
// transaction is accepted, which issues the registered store read; the read
// data is captured, the 17 steps of the bit-serial restoring divider form
// (p - min) * 65536 / (max - min), and the output register is loaded once it
// is free. A flat frame returns the raw pixel. One transaction is worked on
// at a time; a new one is taken as soon as the previous result has moved into
// the output register. No clearing pass runs after reset.
module min_max_normalize
    import mmn_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    mmn_in_if.sink    sample,
    mmn_out_if.source result
);

    mmn_cmd_t    cmd;
    mmn_status_t status;

    mmn_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample.valid),
        .in_op     (sample.op),
        .in_ready  (sample.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    mmn_dpath u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .pixel    (sample.pixel),
        .last     (sample.last),
        .value    (result.value),
        .last_res (result.last_res)
    );

endmodule
